// File: hdl/epc_pkg.sv
// Shared constants for the edge pair compatibility unit.
package epc_pkg;

   // Default coordinate format, unsigned Q12.8.
   localparam int COORD_INT_BITS_DEF  = 12;
   localparam int COORD_FRAC_BITS_DEF = 8;

   // Default score format, unsigned Q1.16 with 2^16 standing for 1.0.
   localparam int SCORE_FRAC_BITS_DEF = 16;

   // Squared lengths are scaled by 2^LEN_SHIFT before the square root.
   localparam int LEN_SHIFT = 16;

endpackage

// File: hdl/edge_pair_compatibility_unit.sv
// Top level of the edge pair compatibility unit.
//
// A pair of edges P and Q is presented on the req_ ports and taken at a
// rising edge where start is high and busy is low. Busy never rises, so a
// new pair may be started in every cycle. The score (angle, scale, position
// and visibility terms multiplied in Q1.SCORE_FRAC_BITS), the compatible
// flag and the degenerate flag come back on the rsp_ ports for one cycle,
// marked by rsp_valid, in the order the pairs were taken.
// L = COORD_INT_BITS + COORD_FRAC_BITS + 10 is the root width of the
// three square root pipelines (one stage per root bit), which with the
// dividers (one stage per quotient bit) set the latency.
// Throughput is one pair per cycle.
// The threshold register is written through the csr_ port, which is always
// ready; write it only while no transfer is in flight.
// Reset clears the in-flight valid bits and loads the threshold with 0.4.
// The receiver cannot stall, so results are never held back.
module edge_pair_compatibility_unit
   import epc_pkg::*;
#(
   parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int SCORE_FRAC_BITS = SCORE_FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_p_start_x,
   input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_p_start_y,
   input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_p_end_x,
   input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_p_end_y,
   input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_q_start_x,
   input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_q_start_y,
   input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_q_end_x,
   input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_q_end_y,
   input  logic                                     req_same_edge,
   output logic                                     rsp_valid,
   output logic [SCORE_FRAC_BITS:0]                 rsp_score,
   output logic                                     rsp_compatible,
   output logic                                     rsp_degenerate,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [SCORE_FRAC_BITS:0]                 csr_data
);

   // Widths that follow from the formats.
   localparam int CW      = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int SW      = SCORE_FRAC_BITS + 1;
   localparam int DW      = CW + 1;
   localparam int MW      = CW + 2;
   localparam int PW      = 2 * DW;
   localparam int MPW     = 2 * MW;
   localparam int PD_W    = 2 * CW + 1;
   localparam int MD_W    = 2 * CW + 3;
   localparam int T_W     = 2 * CW + 2;
   localparam int VW      = 2 * CW + 4;
   localparam int W_W     = 2 * CW + 3;
   localparam int DM_W    = 2 * CW + 1;
   localparam int SQ_IN   = MD_W + LEN_SHIFT;
   localparam int L_W     = (SQ_IN + 1) / 2;
   localparam int AN_W    = DM_W + LEN_SHIFT;
   localparam int LPQ_W   = 2 * L_W;
   localparam int SC_W    = 2 * L_W + 3;
   localparam int LAT_SQ  = L_W + 1;
   localparam int LAT_DIV = SCORE_FRAC_BITS + 2;
   localparam int LEN_AT  = 4 + LAT_SQ;
   localparam int TOT     = LEN_AT + 7 + LAT_DIV;
   localparam int DM_LEN  = LEN_AT - 3;
   localparam int CV_LEN  = LEN_AT - 2;
   localparam int SE_LEN  = TOT - 1;
   localparam int DG_LEN  = TOT - 5;
   localparam logic [SW-1:0] ONE       = {1'b1, {SCORE_FRAC_BITS{1'b0}}};
   localparam logic [SW-1:0] THR_RESET = SW'((2 ** SCORE_FRAC_BITS * 2) / 5);

   // Threshold register.
   logic [SW-1:0] thr_ff;

   // Input stage.
   logic [CW-1:0] p0x_ff, p0y_ff, p1x_ff, p1y_ff, q0x_ff, q0y_ff, q1x_ff, q1y_ff;

   // Differences.
   logic signed [DW-1:0] px_ff, py_ff, qx_ff, qy_ff;
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [MW-1:0] mx_ff, my_ff;

   // Products.
   logic signed [PW-1:0]  pxx_ff, pyy_ff, qxx_ff, qyy_ff, pqx_ff, pqy_ff;
   logic signed [PW-1:0]  apx_ff, apy_ff, bpx_ff, bpy_ff;
   logic signed [PW-1:0]  aqx_ff, aqy_ff, cqx_ff, cqy_ff;
   logic signed [MPW-1:0] mxx_ff, myy_ff;

   // Sums.
   logic [PD_W-1:0]       pd2_ff, qd2_ff;
   logic [MD_W-1:0]       md2_ff;
   logic signed [T_W-1:0] dot_ff, tp0_ff, tp1_ff, tq0_ff, tq1_ff;

   // Visibility terms.
   logic signed [VW-1:0] vdp_ff, vsp_ff, vdq_ff, vsq_ff;
   logic signed [VW-1:0] vdp_abs, vsp_abs, vdq_abs, vsq_abs;
   logic signed [T_W-1:0] dot_abs;
   logic [W_W-1:0]       wp_ff, up_ff, wq_ff, uq_ff;
   logic [W_W-1:0]       vnp_ff, vnq_ff, vwp_ff, vwq_ff;
   logic [SW-1:0]        vpq, vqp;

   // Lengths and the scale and position operands.
   logic [L_W-1:0]   lp, lq, lm;
   logic [L_W-1:0]   a_ff, b_ff, lm_ff;
   logic [L_W:0]     s_ff, s2_ff;
   logic [LPQ_W-1:0] lpq_ff;
   logic [2*L_W:0]   as_ff;
   logic [2*L_W+1:0] ss_ff;
   logic [2*L_W-1:0] ab_ff;
   logic [L_W+1:0]   sl_ff;
   logic [SC_W-1:0]  sn_ff, sd_ff;

   // Terms and the running product.
   logic [SW-1:0]   ca, cs, cp;
   logic [SW-1:0]   ca_ff [2];
   logic [SW-1:0]   cp_ff [2];
   logic [SW-1:0]   cv_ff [CV_LEN];
   logic [2*SW-1:0] m1_prod, m2_prod, m3_prod;
   logic [SW-1:0]   m1_ff, m2_ff, m3_ff;

   // Side data that travels with the pair.
   logic            vld_ff [TOT];
   logic            se_ff  [SE_LEN];
   logic            deg_ff [DG_LEN];
   logic [DM_W-1:0] dm_ff  [DM_LEN];

   // Result registers.
   logic [SW-1:0] score_in;
   logic [SW-1:0] score_ff;
   logic          compat_ff;
   logic          degen_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Threshold register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // Valid bits of the whole pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= start;
         for (int i = 1; i < TOT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Side data delay lines.
   always_ff @(posedge clock) begin
      se_ff[0]  <= req_same_edge;
      for (int i = 1; i < SE_LEN; i++) se_ff[i] <= se_ff[i-1];
      deg_ff[0] <= (pd2_ff == '0) || (qd2_ff == '0);
      for (int i = 1; i < DG_LEN; i++) deg_ff[i] <= deg_ff[i-1];
      dm_ff[0]  <= dot_abs[DM_W-1:0];
      for (int i = 1; i < DM_LEN; i++) dm_ff[i] <= dm_ff[i-1];
   end

   // Capture the coordinates.
   always_ff @(posedge clock) begin
      p0x_ff <= req_p_start_x;
      p0y_ff <= req_p_start_y;
      p1x_ff <= req_p_end_x;
      p1y_ff <= req_p_end_y;
      q0x_ff <= req_q_start_x;
      q0y_ff <= req_q_start_y;
      q1x_ff <= req_q_end_x;
      q1y_ff <= req_q_end_y;
   end

   // Edge vectors, offsets for the projections and the midpoint offset.
   always_ff @(posedge clock) begin
      px_ff <= $signed({1'b0, p1x_ff}) - $signed({1'b0, p0x_ff});
      py_ff <= $signed({1'b0, p1y_ff}) - $signed({1'b0, p0y_ff});
      qx_ff <= $signed({1'b0, q1x_ff}) - $signed({1'b0, q0x_ff});
      qy_ff <= $signed({1'b0, q1y_ff}) - $signed({1'b0, q0y_ff});
      ax_ff <= $signed({1'b0, q0x_ff}) - $signed({1'b0, p0x_ff});
      ay_ff <= $signed({1'b0, q0y_ff}) - $signed({1'b0, p0y_ff});
      bx_ff <= $signed({1'b0, q1x_ff}) - $signed({1'b0, p0x_ff});
      by_ff <= $signed({1'b0, q1y_ff}) - $signed({1'b0, p0y_ff});
      cx_ff <= $signed({1'b0, p1x_ff}) - $signed({1'b0, q0x_ff});
      cy_ff <= $signed({1'b0, p1y_ff}) - $signed({1'b0, q0y_ff});
      mx_ff <= $signed({2'b0, p0x_ff}) + $signed({2'b0, p1x_ff})
             - $signed({2'b0, q0x_ff}) - $signed({2'b0, q1x_ff});
      my_ff <= $signed({2'b0, p0y_ff}) + $signed({2'b0, p1y_ff})
             - $signed({2'b0, q0y_ff}) - $signed({2'b0, q1y_ff});
   end

   // Component products.
   always_ff @(posedge clock) begin
      pxx_ff <= px_ff * px_ff;
      pyy_ff <= py_ff * py_ff;
      qxx_ff <= qx_ff * qx_ff;
      qyy_ff <= qy_ff * qy_ff;
      pqx_ff <= px_ff * qx_ff;
      pqy_ff <= py_ff * qy_ff;
      apx_ff <= ax_ff * px_ff;
      apy_ff <= ay_ff * py_ff;
      bpx_ff <= bx_ff * px_ff;
      bpy_ff <= by_ff * py_ff;
      aqx_ff <= ax_ff * qx_ff;
      aqy_ff <= ay_ff * qy_ff;
      cqx_ff <= cx_ff * qx_ff;
      cqy_ff <= cy_ff * qy_ff;
      mxx_ff <= mx_ff * mx_ff;
      myy_ff <= my_ff * my_ff;
   end

   // Squared lengths, dot product and projections.
   always_ff @(posedge clock) begin
      pd2_ff <= PD_W'(pxx_ff + pyy_ff);
      qd2_ff <= PD_W'(qxx_ff + qyy_ff);
      md2_ff <= MD_W'(mxx_ff + myy_ff);
      dot_ff <= pqx_ff + pqy_ff;
      tp0_ff <= apx_ff + apy_ff;
      tp1_ff <= bpx_ff + bpy_ff;
      tq0_ff <= -aqx_ff - aqy_ff;
      tq1_ff <= cqx_ff + cqy_ff;
   end

   // Projection span and overhang, signed.
   always_ff @(posedge clock) begin
      vdp_ff <= tp0_ff - tp1_ff;
      vsp_ff <= $signed({3'b0, pd2_ff}) - tp0_ff - tp1_ff;
      vdq_ff <= tq0_ff - tq1_ff;
      vsq_ff <= $signed({3'b0, qd2_ff}) - tq0_ff - tq1_ff;
   end

   // Magnitudes.
   assign dot_abs = dot_ff[T_W-1] ? -dot_ff : dot_ff;
   assign vdp_abs = vdp_ff[VW-1] ? -vdp_ff : vdp_ff;
   assign vsp_abs = vsp_ff[VW-1] ? -vsp_ff : vsp_ff;
   assign vdq_abs = vdq_ff[VW-1] ? -vdq_ff : vdq_ff;
   assign vsq_abs = vsq_ff[VW-1] ? -vsq_ff : vsq_ff;

   always_ff @(posedge clock) begin
      wp_ff <= vdp_abs[W_W-1:0];
      up_ff <= vsp_abs[W_W-1:0];
      wq_ff <= vdq_abs[W_W-1:0];
      uq_ff <= vsq_abs[W_W-1:0];
   end

   // Visibility numerators; an overhang at least as long as the span gives zero.
   always_ff @(posedge clock) begin
      vnp_ff <= (up_ff < wp_ff) ? wp_ff - up_ff : '0;
      vnq_ff <= (uq_ff < wq_ff) ? wq_ff - uq_ff : '0;
      vwp_ff <= wp_ff;
      vwq_ff <= wq_ff;
   end

   epc_div #(.NUM_W(W_W), .DEN_W(W_W), .FRAC_W(SCORE_FRAC_BITS)) u_div_vpq (
      .clock (clock),
      .num   (vnp_ff),
      .den   (vwp_ff),
      .quo   (vpq)
   );

   epc_div #(.NUM_W(W_W), .DEN_W(W_W), .FRAC_W(SCORE_FRAC_BITS)) u_div_vqp (
      .clock (clock),
      .num   (vnq_ff),
      .den   (vwq_ff),
      .quo   (vqp)
   );

   // Smaller visibility, held until the product chain needs it.
   always_ff @(posedge clock) begin
      cv_ff[0] <= (vpq < vqp) ? vpq : vqp;
      for (int i = 1; i < CV_LEN; i++) cv_ff[i] <= cv_ff[i-1];
   end

   // Lengths of both edges and of the midpoint offset.
   epc_sqrt #(.IN_W(SQ_IN)) u_sqrt_p (
      .clock (clock),
      .rad   (SQ_IN'({pd2_ff, {LEN_SHIFT{1'b0}}})),
      .root  (lp)
   );

   epc_sqrt #(.IN_W(SQ_IN)) u_sqrt_q (
      .clock (clock),
      .rad   (SQ_IN'({qd2_ff, {LEN_SHIFT{1'b0}}})),
      .root  (lq)
   );

   epc_sqrt #(.IN_W(SQ_IN)) u_sqrt_m (
      .clock (clock),
      .rad   ({md2_ff, {LEN_SHIFT{1'b0}}}),
      .root  (lm)
   );

   // Shorter and longer length, their sum and the angle divisor.
   always_ff @(posedge clock) begin
      a_ff   <= (lp < lq) ? lp : lq;
      b_ff   <= (lp < lq) ? lq : lp;
      s_ff   <= {1'b0, lp} + {1'b0, lq};
      lpq_ff <= lp * lq;
      lm_ff  <= lm;
   end

   epc_div #(.NUM_W(AN_W), .DEN_W(LPQ_W), .FRAC_W(SCORE_FRAC_BITS)) u_div_angle (
      .clock (clock),
      .num   ({dm_ff[DM_LEN-1], {LEN_SHIFT{1'b0}}}),
      .den   (lpq_ff),
      .quo   (ca)
   );

   // Scale products and the position divisor.
   always_ff @(posedge clock) begin
      as_ff <= a_ff * s_ff;
      ss_ff <= s_ff * s_ff;
      ab_ff <= a_ff * b_ff;
      sl_ff <= {1'b0, s_ff} + {2'b0, lm_ff};
      s2_ff <= s_ff;
   end

   epc_div #(.NUM_W(L_W+1), .DEN_W(L_W+2), .FRAC_W(SCORE_FRAC_BITS)) u_div_pos (
      .clock (clock),
      .num   (s2_ff),
      .den   (sl_ff),
      .quo   (cp)
   );

   // Scale numerator and divisor.
   always_ff @(posedge clock) begin
      sn_ff <= {as_ff, 2'b0};
      sd_ff <= SC_W'(ss_ff) + SC_W'({ab_ff, 2'b0});
   end

   epc_div #(.NUM_W(SC_W), .DEN_W(SC_W), .FRAC_W(SCORE_FRAC_BITS)) u_div_scale (
      .clock (clock),
      .num   (sn_ff),
      .den   (sd_ff),
      .quo   (cs)
   );

   // Product chain: angle, scale, position, visibility.
   assign m1_prod = ca_ff[1] * cs;
   assign m2_prod = m1_ff * cp_ff[1];
   assign m3_prod = m2_ff * cv_ff[CV_LEN-1];

   always_ff @(posedge clock) begin
      ca_ff[0] <= ca;
      ca_ff[1] <= ca_ff[0];
      cp_ff[0] <= cp;
      cp_ff[1] <= cp_ff[0];
      m1_ff    <= m1_prod[SCORE_FRAC_BITS +: SW];
      m2_ff    <= m2_prod[SCORE_FRAC_BITS +: SW];
      m3_ff    <= m3_prod[SCORE_FRAC_BITS +: SW];
   end

   // Special cases and the threshold compare.
   always_comb begin
      if (se_ff[SE_LEN-1]) begin
         score_in = ONE;
      end else if (deg_ff[DG_LEN-1]) begin
         score_in = '0;
      end else begin
         score_in = m3_ff;
      end
   end

   always_ff @(posedge clock) begin
      score_ff  <= score_in;
      compat_ff <= score_in >= thr_ff;
      degen_ff  <= deg_ff[DG_LEN-1] && !se_ff[SE_LEN-1];
   end

   assign rsp_valid      = vld_ff[TOT-1];
   assign rsp_score      = score_ff;
   assign rsp_compatible = compat_ff;
   assign rsp_degenerate = degen_ff;

endmodule

// File: hdl/epc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module epc_sqrt
   import epc_pkg::*;
#(
   parameter int IN_W = 2 * (COORD_INT_BITS_DEF + COORD_FRAC_BITS_DEF) + 3 + LEN_SHIFT
) (
   input  logic                      clock,
   input  logic [IN_W-1:0]           rad,
   output logic [(IN_W+1)/2-1:0]     root
);

   localparam int OUT_W = (IN_W + 1) / 2;
   localparam int RW    = 2 * OUT_W;

   // Remainder and partial root of every stage.
   logic [RW-1:0] v_ff [OUT_W+1];
   logic [RW-1:0] r_ff [OUT_W+1];

   // Stage zero takes the radicand.
   always_ff @(posedge clock) begin
      v_ff[0] <= RW'(rad);
      r_ff[0] <= '0;
   end

   // Each stage tries one power of four, from the top down.
   for (genvar k = 1; k <= OUT_W; k++) begin : g_step
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (OUT_W - k));
      logic [RW-1:0] trial;
      logic          take;

      assign trial = r_ff[k-1] + BIT;
      assign take  = v_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (take) begin
            v_ff[k] <= v_ff[k-1] - trial;
            r_ff[k] <= (r_ff[k-1] >> 1) + BIT;
         end else begin
            v_ff[k] <= v_ff[k-1];
            r_ff[k] <= r_ff[k-1] >> 1;
         end
      end
   end

   assign root = r_ff[OUT_W][OUT_W-1:0];

endmodule

// File: hdl/epc_div.sv
// Pipelined saturating fraction divider, one quotient bit per stage.
module epc_div
   import epc_pkg::*;
#(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 32,
   parameter int FRAC_W = SCORE_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [FRAC_W:0]   quo
);

   localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam logic [FRAC_W:0] ONE = {1'b1, {FRAC_W{1'b0}}};

   logic [DEN_W-1:0]  den_ff  [FRAC_W+1];
   logic [DEN_W-1:0]  rem_ff  [FRAC_W+1];
   logic [FRAC_W-1:0] q_ff    [FRAC_W+1];
   logic              zero_ff [FRAC_W+1];
   logic              sat_ff  [FRAC_W+1];
   logic [FRAC_W:0]   quo_ff;

   // Entry stage: flag a zero divisor and a ratio of one or more.
   always_ff @(posedge clock) begin
      den_ff[0]  <= den;
      rem_ff[0]  <= DEN_W'(num);
      q_ff[0]    <= '0;
      zero_ff[0] <= (den == '0);
      sat_ff[0]  <= (CMP_W'(num) >= CMP_W'(den));
   end

   // Restoring division steps.
   for (genvar k = 1; k <= FRAC_W; k++) begin : g_step
      logic [DEN_W:0] shifted;
      logic           take;

      assign shifted = {rem_ff[k-1], 1'b0};
      assign take    = shifted >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         den_ff[k]  <= den_ff[k-1];
         zero_ff[k] <= zero_ff[k-1];
         sat_ff[k]  <= sat_ff[k-1];
         q_ff[k]    <= {q_ff[k-1][FRAC_W-2:0], take};
         if (take) begin
            rem_ff[k] <= DEN_W'(shifted - {1'b0, den_ff[k-1]});
         end else begin
            rem_ff[k] <= DEN_W'(shifted);
         end
      end
   end

   // Final selection of the special cases.
   always_ff @(posedge clock) begin
      if (zero_ff[FRAC_W]) begin
         quo_ff <= '0;
      end else if (sat_ff[FRAC_W]) begin
         quo_ff <= ONE;
      end else begin
         quo_ff <= {1'b0, q_ff[FRAC_W]};
      end
   end

   assign quo = quo_ff;

endmodule
